>>> src/hjc_pkg.sv
// Constants, types and helpers for the Hangul jamo composer.
// No dependencies; imported by hangul_jamo_composer_unit.
`default_nettype none

package hjc_pkg;

  localparam logic [15:0] LEAD_FIRST  = 16'h1100;
  localparam logic [15:0] LEAD_LAST   = 16'h1112;
  localparam logic [15:0] VOWEL_FIRST = 16'h1161;
  localparam logic [15:0] VOWEL_LAST  = 16'h1175;
  localparam logic [15:0] TRAIL_FIRST = 16'h11A8;
  localparam logic [15:0] TRAIL_LAST  = 16'h11C2;
  localparam logic [15:0] TRAIL_BASE  = 16'h11A7;
  localparam logic [15:0] SYLL_BASE   = 16'hAC00;
  localparam int unsigned TRAIL_SPAN  = 28;
  localparam int unsigned VOWEL_SPAN  = 21;
  localparam logic [15:0] LEAD_STRIDE  = 16'(TRAIL_SPAN * VOWEL_SPAN);
  localparam logic [15:0] VOWEL_STRIDE = 16'(TRAIL_SPAN);

  // Jamo offsets all fit in 5 bits (lead < 19, vowel < 21, trail < 28).
  localparam int unsigned OFS_W = 5;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_LEAD  = 2'd1,
    CLS_VOWEL = 2'd2,
    CLS_TRAIL = 2'd3
  } jamo_cls_t;

  // One result item.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        done;
  } res_t;

  function automatic jamo_cls_t jamo_class(input logic [15:0] c);
    jamo_cls_t cls;
    if (c >= LEAD_FIRST && c <= LEAD_LAST) begin
      cls = CLS_LEAD;
    end else if (c >= VOWEL_FIRST && c <= VOWEL_LAST) begin
      cls = CLS_VOWEL;
    end else if (c >= TRAIL_FIRST && c <= TRAIL_LAST) begin
      cls = CLS_TRAIL;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // Precomposed syllable; trail_ofs is zero for a syllable without trail.
  function automatic logic [15:0] make_syllable(input logic [15:0]      lead,
                                                input logic [15:0]      vowel,
                                                input logic [OFS_W-1:0] trail_ofs);
    logic [15:0]      l16;
    logic [15:0]      v16;
    logic [OFS_W-1:0] l;
    logic [OFS_W-1:0] v;
    l16 = lead - LEAD_FIRST;
    v16 = vowel - VOWEL_FIRST;
    l   = l16[OFS_W-1:0];
    v   = v16[OFS_W-1:0];
    return SYLL_BASE + 16'(l) * LEAD_STRIDE + 16'(v) * VOWEL_STRIDE + 16'(trail_ofs);
  endfunction

endpackage

`default_nettype wire

>>> src/hangul_jamo_composer_unit.sv
// Hangul jamo composer: input register, composition logic, two-slot result buffer.
// The first result is written to the result buffer when the item moves on from the input register.
// Throughput: one item per cycle while out_stall is low and each item gives zero or one result; an item that
// gives two results holds the single result port until both results have been taken.
// Reset (rst_n low, synchronous): pending jamo cleared, both stages emptied.
// Depends on hjc_pkg.
`default_nettype none

module hangul_jamo_composer_unit
  import hjc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_unit,
  output logic             out_last_of_run,
  output logic             out_text_done
);

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_code_r;
  logic        s1_eot_r;

  // pending jamo
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [15:0] plead_r, plead_nxt;
  logic [15:0] pvowel_r, pvowel_nxt;

  // result buffer
  logic [1:0]  ob_cnt_r, ob_cnt_nxt;
  res_t        ob0_r, ob0_nxt;
  res_t        ob1_r, ob1_nxt;

  logic        in_accept;
  logic        out_take;
  logic        move;

  jamo_cls_t        cls;
  logic [1:0]       pc_eff;
  logic [15:0]      flush_unit;
  logic [15:0]      trail_diff;
  logic [15:0]      eot_unit;
  logic [15:0]      u0, u1;
  logic [1:0]       n;

  assign out_valid       = (ob_cnt_r != 2'd0);
  assign out_unit        = ob0_r.unit;
  assign out_last_of_run = ob0_r.last;
  assign out_text_done   = ob0_r.done;

  assign out_take  = out_valid && !out_stall;
  // the item in the input register moves on once the buffer has room for two results
  assign move      = s1_valid_r && ((ob_cnt_r == 2'd0) || (ob_cnt_r == 2'd1 && out_take));
  assign in_stall  = s1_valid_r && !move;
  assign in_accept = in_valid && !in_stall;

  // composition
  always_comb begin
    cls        = jamo_class(s1_code_r);
    pc_eff     = (pcnt_r == 2'd3) ? 2'd0 : pcnt_r;
    flush_unit = (pc_eff == 2'd1) ? plead_r : make_syllable(plead_r, pvowel_r, '0);
    trail_diff = s1_code_r - TRAIL_BASE;
    u0         = '0;
    u1         = '0;
    n          = 2'd0;
    pcnt_nxt   = 2'd0;
    plead_nxt  = plead_r;
    pvowel_nxt = pvowel_r;

    case (cls)
      CLS_LEAD: begin
        if (pc_eff != 2'd0) begin
          u0 = flush_unit;
          n  = 2'd1;
        end
        plead_nxt = s1_code_r;
        pcnt_nxt  = 2'd1;
      end
      CLS_VOWEL: begin
        if (pc_eff == 2'd1) begin
          pvowel_nxt = s1_code_r;
          pcnt_nxt   = 2'd2;
        end else if (pc_eff == 2'd2) begin
          u0 = flush_unit;
          u1 = s1_code_r;
          n  = 2'd2;
        end else begin
          u0 = s1_code_r;
          n  = 2'd1;
        end
      end
      CLS_TRAIL: begin
        if (pc_eff == 2'd2) begin
          u0 = make_syllable(plead_r, pvowel_r, trail_diff[OFS_W-1:0]);
          n  = 2'd1;
        end else if (pc_eff == 2'd1) begin
          u0 = plead_r;
          u1 = s1_code_r;
          n  = 2'd2;
        end else begin
          u0 = s1_code_r;
          n  = 2'd1;
        end
      end
      default: begin
        if (pc_eff != 2'd0) begin
          u0 = flush_unit;
          u1 = s1_code_r;
          n  = 2'd2;
        end else begin
          u0 = s1_code_r;
          n  = 2'd1;
        end
      end
    endcase

    // end of text flushes whatever is left pending
    eot_unit = (pcnt_nxt == 2'd1) ? plead_nxt : make_syllable(plead_nxt, pvowel_nxt, '0);
    if (s1_eot_r && pcnt_nxt != 2'd0) begin
      if (n == 2'd0) begin
        u0 = eot_unit;
      end else begin
        u1 = eot_unit;
      end
      n        = n + 2'd1;
      pcnt_nxt = 2'd0;
    end
  end

  // buffer and input stage next state
  always_comb begin
    s1_valid_nxt = in_accept || (s1_valid_r && !move);
    ob_cnt_nxt   = ob_cnt_r;
    ob0_nxt      = ob0_r;
    ob1_nxt      = ob1_r;
    if (move) begin
      ob_cnt_nxt   = n;
      ob0_nxt.unit = u0;
      ob0_nxt.last = (n == 2'd1);
      ob0_nxt.done = s1_eot_r && (n == 2'd1);
      ob1_nxt.unit = u1;
      ob1_nxt.last = (n == 2'd2);
      ob1_nxt.done = s1_eot_r && (n == 2'd2);
    end else if (out_take) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
      ob0_nxt    = ob1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ob_cnt_r   <= 2'd0;
      pcnt_r     <= 2'd0;
      plead_r    <= '0;
      pvowel_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      ob_cnt_r   <= ob_cnt_nxt;
      if (move) begin
        pcnt_r   <= pcnt_nxt;
        plead_r  <= plead_nxt;
        pvowel_r <= pvowel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code_r <= in_code_unit;
      s1_eot_r  <= in_end_of_text;
    end
    ob0_r <= ob0_nxt;
    ob1_r <= ob1_nxt;
  end

endmodule

`default_nettype wire
